// ===== src/gpio_port_lat_tris_adc_regs_core_macros.svh =====
// Assertion macros for the GPIO port register block.
// Included by the top level; needs nothing else.
`ifndef GPIO_PORT_LAT_TRIS_ADC_REGS_CORE_MACROS_SVH
`define GPIO_PORT_LAT_TRIS_ADC_REGS_CORE_MACROS_SVH
`ifndef SYNTH
`define GPRT_ASSERT(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("gprt assertion failed");
`define GPRT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gprt assertion failed");
`else
`define GPRT_ASSERT(name, clk, rstn, expr)
`define GPRT_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

// ===== src/gprt_pkg.sv =====
// Shared types and constants of the GPIO port register block.
// No dependencies.
package gprt_pkg;

    localparam int NUM_PORTS_DEF  = 5;
    localparam int REG_COUNT_DEF  = 128;
    localparam int NUM_ANALOG_DEF = 13;

    localparam logic [6:0] LAT_BASE    = 7'h09;
    localparam logic [6:0] TRIS_BASE   = 7'h12;
    localparam logic [6:0] ADCON2_ADDR = 7'h40;
    localparam logic [6:0] ADCON1_ADDR = 7'h41;
    localparam logic [6:0] ADCON0_ADDR = 7'h42;
    localparam logic [6:0] ADRESL_ADDR = 7'h43;
    localparam logic [6:0] ADRESH_ADDR = 7'h44;

    localparam logic [3:0] ANALOG_CAP  = 4'd13;
    localparam logic [3:0] CHAN_MAX    = 4'd12;
    localparam logic [3:0] CHAN_LIMIT  = 4'hF;
    localparam logic [7:0] GO_CLEAR    = 8'hFD;
    localparam logic [7:0] ALL_INPUTS  = 8'hFF;

    typedef enum logic [3:0] {
        OP_WRITE       = 4'd0,
        OP_SET_MASK    = 4'd1,
        OP_CLEAR_MASK  = 4'd2,
        OP_READ        = 4'd3,
        OP_TEST_MASK   = 4'd4,
        OP_EXT_WRITE   = 4'd5,
        OP_EXT_BIT_SET = 4'd6,
        OP_EXT_BIT_CLR = 4'd7,
        OP_ANALOG_SET  = 4'd8
    } opcode_t;

    typedef enum logic [3:0] {
        KIND_MEM,
        KIND_PORT,
        KIND_LAT,
        KIND_TRIS,
        KIND_ADCON0,
        KIND_ADCON1,
        KIND_ADCON2,
        KIND_ADRESL,
        KIND_ADRESH
    } reg_kind_t;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [6:0]  reg_addr;
        logic [7:0]  data;
        logic [7:0]  bit_mask;
        logic [2:0]  bit_index;
        logic [2:0]  port_select;
        logic [3:0]  analog_channel;
        logic [9:0]  analog_value;
    } item_t;

    // Current contents of the registers that one transaction touches.
    typedef struct packed {
        logic [7:0] port;
        logic [7:0] lat;
        logic [7:0] tris;
        logic [7:0] adcon0;
        logic [7:0] adcon1;
        logic [7:0] adcon2;
        logic [7:0] adresl;
        logic [7:0] adresh;
        logic [7:0] mem_rd;
        logic [3:0] last_count;
        logic       count_known;
    } cur_t;

    // Register updates produced by one transaction.
    typedef struct packed {
        logic       port_we;
        logic [7:0] port_wdata;
        logic       lat_we;
        logic [7:0] lat_val;
        logic       tris_we;
        logic [7:0] tris_wdata;
        logic       adcon0_we;
        logic [7:0] adcon0_val;
        logic       adcon1_we;
        logic       adcon2_we;
        logic       adresl_we;
        logic [7:0] adresl_val;
        logic       adresh_we;
        logic [7:0] adresh_val;
        logic       mem_we;
        logic [7:0] core_val;
        logic       cnt_we;
        logic [3:0] cnt_val;
        logic       analog_we;
    } upd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       port_event;
        logic [2:0] port_number;
        logic [7:0] port_level;
        logic       direction_event;
        logic [7:0] direction_value;
        logic       analog_cfg_event;
        logic [3:0] analog_count;
        logic       warning;
    } result_t;

endpackage

// ===== src/gprt_mem.sv =====
// General purpose register memory with per-entry valid bits and a registered read.
// Uses no package; the write of the current cycle is forwarded to the read.
module gprt_mem #(
    parameter int REG_COUNT = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(REG_COUNT)-1:0] rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(REG_COUNT)-1:0] wr_addr,
    input  logic [7:0]                   wr_data,
    output logic [7:0]                   rd_data
);
    logic [7:0]           mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [7:0]           mem_q_reg;
    logic                 hit_reg;
    logic                 fwd_reg;
    logic [7:0]           fwd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // The array read sees the old contents; a write to the same address in
    // the same cycle is captured separately and takes priority.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            hit_reg      <= valid_reg[rd_addr];
            fwd_reg      <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : (hit_reg ? mem_q_reg : 8'd0);
endmodule

// ===== src/gprt_exec.sv =====
// Single-pass transaction logic: result fields and register updates.
// Depends on gprt_pkg.
module gprt_exec
    import gprt_pkg::*;
#(
    parameter int NUM_ANALOG = NUM_ANALOG_DEF
) (
    input  item_t     item,
    input  reg_kind_t kind,
    input  logic      port_ok,
    input  cur_t      cur,
    input  logic [9:0] analog_levels [NUM_ANALOG],
    output result_t   res,
    output upd_t      upd
);
    localparam int AIDX_W = (NUM_ANALOG > 1) ? $clog2(NUM_ANALOG) : 1;

    logic [7:0] old_val;
    logic [7:0] nv;
    logic [7:0] bmask;
    logic [7:0] drive_val;
    logic [7:0] turn;
    logic [7:0] tris_port;
    logic [7:0] ext_val;
    logic [7:0] cfg_a0;
    logic [7:0] cfg_a1;
    logic [3:0] cfg_a1n;
    logic [3:0] cfg_count;
    logic       cfg_chg;
    logic [3:0] conv_chan;
    logic       conv_ok;
    logic [9:0] conv_lvl;
    logic       conv_warn;
    logic       set_ok;

    always_comb
    begin
        case (kind)
            KIND_PORT:   old_val = cur.port;
            KIND_LAT:    old_val = cur.lat;
            KIND_TRIS:   old_val = cur.tris;
            KIND_ADCON0: old_val = cur.adcon0;
            KIND_ADCON1: old_val = cur.adcon1;
            KIND_ADCON2: old_val = cur.adcon2;
            KIND_ADRESL: old_val = cur.adresl;
            KIND_ADRESH: old_val = cur.adresh;
            default:     old_val = cur.mem_rd;
        endcase
    end

    always_comb
    begin
        case (item.opcode)
            OP_SET_MASK:   nv = old_val | item.bit_mask;
            OP_CLEAR_MASK: nv = old_val & ~item.bit_mask;
            default:       nv = item.data;
        endcase
    end

    assign bmask     = 8'b1 << item.bit_index;
    assign drive_val = (cur.port & cur.tris) | (nv & ~cur.tris);
    // Bits that turn from input to output take the latch value.
    assign turn      = cur.tris & ~nv;
    assign tris_port = (cur.port & ~turn) | (cur.lat & turn);
    assign ext_val   = (item.opcode == OP_EXT_BIT_SET) ? (cur.port | bmask)
                                                       : (cur.port & ~bmask);

    assign cfg_a0    = (kind == KIND_ADCON0) ? nv : cur.adcon0;
    assign cfg_a1    = (kind == KIND_ADCON1) ? nv : cur.adcon1;
    assign cfg_a1n   = CHAN_LIMIT - cfg_a1[3:0];
    assign cfg_count = !cfg_a0[0] ? 4'd0 :
                       ((cfg_a1n > ANALOG_CAP) ? ANALOG_CAP : cfg_a1n);
    assign cfg_chg   = !cur.count_known || (cfg_count != cur.last_count);

    assign conv_chan = nv[5:2];
    assign conv_ok   = ({1'b0, conv_chan} < 5'(NUM_ANALOG));
    assign conv_lvl  = conv_ok ? analog_levels[conv_chan[AIDX_W-1:0]] : 10'd0;
    assign conv_warn = (({1'b0, conv_chan} + {1'b0, cur.adcon1[3:0]}) >= {1'b0, CHAN_LIMIT})
                       || !cur.adcon2[7] || (conv_chan > CHAN_MAX);
    assign set_ok    = ({1'b0, item.analog_channel} < 5'(NUM_ANALOG));

    always_comb
    begin
        res = '0;
        upd = '0;
        upd.core_val = nv;
        case (item.opcode)
            OP_WRITE, OP_SET_MASK, OP_CLEAR_MASK:
            begin
                case (kind)
                    KIND_PORT:
                    begin
                        upd.lat_we  = 1'b1;
                        upd.lat_val = nv;
                        if (old_val != nv)
                        begin
                            if (cur.tris == ALL_INPUTS)
                            begin
                                res.warning = 1'b1;
                            end
                            else if (drive_val != cur.port)
                            begin
                                upd.port_we    = 1'b1;
                                upd.port_wdata = drive_val;
                            end
                        end
                    end
                    KIND_LAT:
                    begin
                        upd.lat_we  = 1'b1;
                        upd.lat_val = nv;
                        if ((old_val != nv) && (drive_val != cur.port))
                        begin
                            upd.port_we    = 1'b1;
                            upd.port_wdata = drive_val;
                        end
                    end
                    KIND_TRIS:
                    begin
                        if (old_val != nv)
                        begin
                            upd.tris_we         = 1'b1;
                            upd.tris_wdata      = nv;
                            res.direction_event = 1'b1;
                            res.direction_value = nv;
                            if (tris_port != cur.port)
                            begin
                                upd.port_we    = 1'b1;
                                upd.port_wdata = tris_port;
                            end
                        end
                    end
                    KIND_ADCON0:
                    begin
                        upd.adcon0_we  = 1'b1;
                        upd.adcon0_val = nv;
                        if (cfg_chg)
                        begin
                            upd.cnt_we = 1'b1;
                        end
                        if (nv[1:0] != 2'b00)
                        begin
                            upd.adcon0_val = nv & GO_CLEAR;
                            upd.adresh_we  = 1'b1;
                            upd.adresh_val = {6'd0, conv_lvl[9:8]};
                            upd.adresl_we  = 1'b1;
                            upd.adresl_val = conv_lvl[7:0];
                            res.warning    = conv_warn;
                        end
                    end
                    KIND_ADCON1:
                    begin
                        upd.adcon1_we = 1'b1;
                        upd.cnt_we    = cfg_chg;
                    end
                    KIND_ADCON2:
                    begin
                        upd.adcon2_we = 1'b1;
                        upd.cnt_we    = cfg_chg;
                    end
                    KIND_ADRESL:
                    begin
                        upd.adresl_we  = 1'b1;
                        upd.adresl_val = nv;
                    end
                    KIND_ADRESH:
                    begin
                        upd.adresh_we  = 1'b1;
                        upd.adresh_val = nv;
                    end
                    default:
                    begin
                        upd.mem_we = 1'b1;
                    end
                endcase
            end
            OP_READ:
            begin
                res.read_data = old_val;
            end
            OP_TEST_MASK:
            begin
                res.read_data = {7'd0, |(old_val & item.bit_mask)};
            end
            OP_EXT_WRITE:
            begin
                if (port_ok)
                begin
                    res.warning = |(item.data & ~cur.tris);
                    if (cur.port != item.data)
                    begin
                        upd.port_we    = 1'b1;
                        upd.port_wdata = item.data;
                    end
                end
            end
            OP_EXT_BIT_SET, OP_EXT_BIT_CLR:
            begin
                if (port_ok)
                begin
                    res.warning = ~|(cur.tris & bmask);
                    if (cur.port != ext_val)
                    begin
                        upd.port_we    = 1'b1;
                        upd.port_wdata = ext_val;
                    end
                end
            end
            OP_ANALOG_SET:
            begin
                upd.analog_we = set_ok;
            end
            default:
            begin
            end
        endcase

        upd.cnt_val = cfg_count;
        if (upd.cnt_we)
        begin
            res.analog_cfg_event = 1'b1;
            res.analog_count     = cfg_count;
        end
        if (upd.port_we)
        begin
            res.port_event = 1'b1;
            res.port_level = upd.port_wdata;
        end
    end
endmodule

// ===== src/gpio_port_lat_tris_adc_regs_core.sv =====
// Top level of the GPIO port register block with LAT/TRIS shadowing and ADC registers.
// Depends on gprt_pkg, gprt_mem, gprt_exec and the assertion macro header.
//
// Usage: each input transaction (in_valid, in_stall, opcode and operand ports)
// carries one core register access, one outside port operation or one analog
// level update. Every transaction produces exactly one result transaction on
// out_valid/out_stall with the read data, port, direction and analog events
// and a warning flag.
// An accepted transaction passes from the input register to the result
// register. Throughput: one transaction per cycle while out_stall is low.
// The input register and the result register each hold one transaction;
// the combinational path between them is set by the old-value select, the
// 8-bit masking and the event compares.
// When the receiver stalls, the result register holds its transaction, the
// input register fills and in_stall rises, so nothing is lost or repeated.
// Reset clears the ports, LAT, TRIS, ADC registers, analog levels and the
// analog count tracker at once; the general registers live in a memory whose
// per-entry valid bits reset clears, so no clearing pass is needed and the
// block takes transactions from the first cycle after reset.
`include "gpio_port_lat_tris_adc_regs_core_macros.svh"

module gpio_port_lat_tris_adc_regs_core
    import gprt_pkg::*;
#(
    parameter int NUM_PORTS  = NUM_PORTS_DEF,
    parameter int REG_COUNT  = REG_COUNT_DEF,
    parameter int NUM_ANALOG = NUM_ANALOG_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] opcode,
    input  logic [6:0] reg_addr,
    input  logic [7:0] data,
    input  logic [7:0] bit_mask,
    input  logic [2:0] bit_index,
    input  logic [2:0] port_select,
    input  logic [3:0] analog_channel,
    input  logic [9:0] analog_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       port_event,
    output logic [2:0] port_number,
    output logic [7:0] port_level,
    output logic       direction_event,
    output logic [7:0] direction_value,
    output logic       analog_cfg_event,
    output logic [3:0] analog_count,
    output logic       warning
);
    localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int AIDX_W = (NUM_ANALOG > 1) ? $clog2(NUM_ANALOG) : 1;
    localparam int MEM_AW = $clog2(REG_COUNT);

    // Handshake control.
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic accept;
    logic process;

    // Input register: the transaction, its register class and its port index.
    item_t             item_reg, item_next;
    reg_kind_t         kind_reg, kind_next;
    logic [PIDX_W-1:0] p_reg, p_next;
    logic              port_ok_reg, port_ok_next;

    result_t result_reg;
    result_t res;
    result_t res_out;
    upd_t    upd;
    cur_t    cur;
    logic [7:0] mem_rd;

    // Architectural registers kept in flip-flops.
    logic [7:0] port_reg [NUM_PORTS];
    logic [7:0] lat_reg  [NUM_PORTS];
    logic [7:0] tris_reg [NUM_PORTS];
    logic [7:0] adcon0_reg, adcon1_reg, adcon2_reg;
    logic [7:0] adresl_reg, adresh_reg;
    logic [3:0] last_count_reg;
    logic       count_known_reg;
    logic [9:0] analog_reg [NUM_ANALOG];

    // A transaction moves to the result register whenever that register is
    // empty or is being emptied in the same cycle.
    assign process  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !process;
    assign accept   = in_valid && !in_stall;

    assign in_valid_next  = accept ? 1'b1 : (process ? 1'b0 : in_valid_reg);
    assign out_valid_next = process ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    assign item_next = '{
        opcode:         opcode,
        reg_addr:       reg_addr,
        data:           data,
        bit_mask:       bit_mask,
        bit_index:      bit_index,
        port_select:    port_select,
        analog_channel: analog_channel,
        analog_value:   analog_value
    };

    // Classify the register address while the transaction is accepted.
    always_comb
    begin
        if (reg_addr < 7'(NUM_PORTS))
        begin
            kind_next = KIND_PORT;
        end
        else if ((reg_addr >= LAT_BASE) && (reg_addr < (LAT_BASE + 7'(NUM_PORTS))))
        begin
            kind_next = KIND_LAT;
        end
        else if ((reg_addr >= TRIS_BASE) && (reg_addr < (TRIS_BASE + 7'(NUM_PORTS))))
        begin
            kind_next = KIND_TRIS;
        end
        else if (reg_addr == ADCON0_ADDR)
        begin
            kind_next = KIND_ADCON0;
        end
        else if (reg_addr == ADCON1_ADDR)
        begin
            kind_next = KIND_ADCON1;
        end
        else if (reg_addr == ADCON2_ADDR)
        begin
            kind_next = KIND_ADCON2;
        end
        else if (reg_addr == ADRESL_ADDR)
        begin
            kind_next = KIND_ADRESL;
        end
        else if (reg_addr == ADRESH_ADDR)
        begin
            kind_next = KIND_ADRESH;
        end
        else
        begin
            kind_next = KIND_MEM;
        end
    end

    // Outside operations name the port directly; core accesses derive it
    // from the address offset within the port, LAT or TRIS window.
    logic [6:0] lat_off, tris_off;
    assign lat_off  = reg_addr - LAT_BASE;
    assign tris_off = reg_addr - TRIS_BASE;

    always_comb
    begin
        if ((opcode == OP_EXT_WRITE) || (opcode == OP_EXT_BIT_SET) ||
            (opcode == OP_EXT_BIT_CLR))
        begin
            p_next = port_select[PIDX_W-1:0];
        end
        else
        begin
            case (kind_next)
                KIND_LAT:  p_next = lat_off[PIDX_W-1:0];
                KIND_TRIS: p_next = tris_off[PIDX_W-1:0];
                default:   p_next = reg_addr[PIDX_W-1:0];
            endcase
        end
    end

    assign port_ok_next = ({1'b0, port_select} < 4'(NUM_PORTS));

    gprt_mem #(
        .REG_COUNT(REG_COUNT)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (MEM_AW'(reg_addr)),
        .wr_en   (process && upd.mem_we),
        .wr_addr (MEM_AW'(item_reg.reg_addr)),
        .wr_data (upd.core_val),
        .rd_data (mem_rd)
    );

    assign cur = '{
        port:        port_reg[p_reg],
        lat:         lat_reg[p_reg],
        tris:        tris_reg[p_reg],
        adcon0:      adcon0_reg,
        adcon1:      adcon1_reg,
        adcon2:      adcon2_reg,
        adresl:      adresl_reg,
        adresh:      adresh_reg,
        mem_rd:      mem_rd,
        last_count:  last_count_reg,
        count_known: count_known_reg
    };

    gprt_exec #(
        .NUM_ANALOG(NUM_ANALOG)
    ) u_exec (
        .item          (item_reg),
        .kind          (kind_reg),
        .port_ok       (port_ok_reg),
        .cur           (cur),
        .analog_levels (analog_reg),
        .res           (res),
        .upd           (upd)
    );

    // The port number is only reported alongside a port or direction event.
    always_comb
    begin
        res_out             = res;
        res_out.port_number = (res.port_event || res.direction_event) ? 3'(p_reg) : 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            adcon0_reg      <= '0;
            adcon1_reg      <= '0;
            adcon2_reg      <= '0;
            adresl_reg      <= '0;
            adresh_reg      <= '0;
            last_count_reg  <= '0;
            count_known_reg <= 1'b0;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                port_reg[i] <= '0;
                lat_reg[i]  <= '0;
                tris_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_ANALOG; i++)
            begin
                analog_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (process)
            begin
                if (upd.port_we)
                begin
                    port_reg[p_reg] <= upd.port_wdata;
                end
                if (upd.lat_we)
                begin
                    lat_reg[p_reg] <= upd.lat_val;
                end
                if (upd.tris_we)
                begin
                    tris_reg[p_reg] <= upd.tris_wdata;
                end
                if (upd.adcon0_we)
                begin
                    adcon0_reg <= upd.adcon0_val;
                end
                if (upd.adcon1_we)
                begin
                    adcon1_reg <= upd.core_val;
                end
                if (upd.adcon2_we)
                begin
                    adcon2_reg <= upd.core_val;
                end
                if (upd.adresl_we)
                begin
                    adresl_reg <= upd.adresl_val;
                end
                if (upd.adresh_we)
                begin
                    adresh_reg <= upd.adresh_val;
                end
                if (upd.cnt_we)
                begin
                    last_count_reg  <= upd.cnt_val;
                    count_known_reg <= 1'b1;
                end
                if (upd.analog_we)
                begin
                    analog_reg[item_reg.analog_channel[AIDX_W-1:0]] <= item_reg.analog_value;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg    <= item_next;
            kind_reg    <= kind_next;
            p_reg       <= p_next;
            port_ok_reg <= port_ok_next;
        end
        if (process)
        begin
            result_reg <= res_out;
        end
    end

    assign out_valid        = out_valid_reg;
    assign read_data        = result_reg.read_data;
    assign port_event       = result_reg.port_event;
    assign port_number      = result_reg.port_number;
    assign port_level       = result_reg.port_level;
    assign direction_event  = result_reg.direction_event;
    assign direction_value  = result_reg.direction_value;
    assign analog_cfg_event = result_reg.analog_cfg_event;
    assign analog_count     = result_reg.analog_count;
    assign warning          = result_reg.warning;

    // A processed transaction always shows up in the result register.
    `GPRT_ASSERT_NEXT(a_proc_out, clk, rst_n, process, out_valid_reg)
    // A stalled input transaction stays in the input register.
    `GPRT_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !process, in_valid_reg)
    // Every conversion start clears the GO bit, so it never stays set.
    `GPRT_ASSERT(a_go_clear, clk, rst_n, !adcon0_reg[1])
    // The tracked analog channel count never exceeds the cap.
    `GPRT_ASSERT(a_cnt_cap, clk, rst_n, last_count_reg <= ANALOG_CAP)
    // Port and direction events always name an existing port.
    `GPRT_ASSERT(a_evt_port, clk, rst_n, !(out_valid && (port_event || direction_event)) || (4'(port_number) < 4'(NUM_PORTS)))
endmodule
